FILE: hdl/assert_macros.svh
// Assertion helpers for the poller checker.
// Both expect signals clk and rst_n in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define SGP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("poller check failed");

// Next-cycle implication, held off during reset
`define SGP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("poller check failed");

`endif

FILE: hdl/sgp_pkg.sv
package sgp_pkg;

    // Number of bits clocked out of the pad per poll
    localparam int unsigned BITS_READ = 15;

    // Stream widths
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 32;
    localparam int unsigned OUT_USER_W = 1;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LATCH_TICKS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLK_HI_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UP_VALUE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_VALUE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_VALUE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_VALUE  = 3'd7;

    // Reset values of the registers
    localparam logic [7:0]        RST_LATCH_TICKS  = 8'd12;
    localparam logic [7:0]        RST_SETTLE_TICKS = 8'd6;
    localparam logic [7:0]        RST_CLK_HI_TICKS = 8'd12;
    localparam logic [15:0]       RST_GAP_TICKS    = 16'd16466;
    localparam logic signed [7:0] RST_UP_VALUE     = -8'sd127;
    localparam logic signed [7:0] RST_DOWN_VALUE   = 8'sd127;
    localparam logic signed [7:0] RST_LEFT_VALUE   = -8'sd127;
    localparam logic signed [7:0] RST_RIGHT_VALUE  = 8'sd127;

    // Bit positions in the read order
    localparam logic [3:0] BIT_UP    = 4'd4;
    localparam logic [3:0] BIT_DOWN  = 4'd5;
    localparam logic [3:0] BIT_LEFT  = 4'd6;
    localparam logic [3:0] BIT_RIGHT = 4'd7;

    // Bit positions in the output word and user field
    localparam int unsigned OUT_LATCH_POS = 0;
    localparam int unsigned OUT_CLOCK_POS = 1;
    localparam int unsigned OUT_USER_RV   = 0;

    typedef enum logic [2:0] {
        PH_LATCH  = 3'd0,
        PH_SETTLE = 3'd1,
        PH_HIGH   = 3'd2,
        PH_LOW    = 3'd3,
        PH_GAP    = 3'd4
    } phase_t;

endpackage

FILE: hdl/serial_gamepad_poller.sv
// Serial gamepad poller.
// Input stream: one word per microsecond tick, s_tdata[0] is the sampled pad
// data line (low = pressed). Output stream: one word per accepted tick with
// the latch and clock drive levels for that tick and the last published
// report (buttons, x axis, y axis); m_tuser[0] flags the tick on which a
// fresh report is published.
// Each poll: latch high for latch_ticks, settle for settle_ticks (bit 0 read
// on the last settle tick), then per further bit a clock-high pulse of
// clock_high_ticks sampled on its last tick and one clock-low tick, then a
// frame gap of frame_gap_ticks.
// The result word is in the output register in the cycle after its tick is
// accepted. Throughput: one tick per cycle while the output is not stalled,
// set by the single output register; a new tick is taken while the result
// waits if the receiver takes it in the same cycle.
// Stall: with m_tvalid high and m_tready low the output holds and s_tready
// drops, so no tick is taken and the poll sequence pauses.
// Reset: registers return to their defaults, the poll restarts in the latch
// phase and the published report reads zero. Write configuration while idle.
module serial_gamepad_poller (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sgp_pkg::IN_DATA_W-1:0]     s_tdata,   // [0] data_line
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] latch_pin, [1] clock_pin, [9:2] buttons, [17:10] x_axis,
    // [25:18] y_axis, rest zero
    output logic [sgp_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic [sgp_pkg::OUT_USER_W-1:0]    m_tuser,   // [0] report_valid
    input  logic                              cfg_we,
    input  logic [sgp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sgp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import sgp_pkg::*;

    // Configuration registers
    logic [7:0]        latch_ticks_reg;
    logic [7:0]        settle_ticks_reg;
    logic [7:0]        clk_hi_ticks_reg;
    logic [15:0]       gap_ticks_reg;
    logic signed [7:0] up_value_reg;
    logic signed [7:0] down_value_reg;
    logic signed [7:0] left_value_reg;
    logic signed [7:0] right_value_reg;

    // Poll state
    phase_t            phase_reg, phase_next;
    logic [15:0]       tick_reg, tick_next;
    logic [3:0]        bit_reg, bit_next;
    logic [7:0]        btn_reg, btn_next;
    logic signed [7:0] x_reg, x_next;
    logic signed [7:0] y_reg, y_next;
    logic [7:0]        pub_btn_reg, pub_btn_next;
    logic signed [7:0] pub_x_reg, pub_x_next;
    logic signed [7:0] pub_y_reg, pub_y_next;

    // Output register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [OUT_USER_W-1:0] out_user_reg, out_user_next;

    logic        accept;
    logic        pressed;
    logic [16:0] tick_inc;
    logic        run_done;
    logic [7:0]  run_len8;
    logic [15:0] run_len;
    logic        last_bit;
    logic        lpin, cpin, rv;
    logic        sample_en;
    logic [3:0]  sample_idx;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign pressed  = !s_tdata[0];
    assign tick_inc = {1'b0, tick_reg} + 17'd1;
    assign last_bit = ({1'b0, bit_reg} + 5'd1) >= 5'(BITS_READ) || bit_reg == 4'hF;

    // Length of the run in the current phase
    always_comb
    begin
        case (phase_reg)
            PH_SETTLE: run_len8 = settle_ticks_reg;
            PH_HIGH:   run_len8 = clk_hi_ticks_reg;
            default:   run_len8 = latch_ticks_reg;
        endcase
        run_len  = (phase_reg == PH_GAP) ? gap_ticks_reg : {8'd0, run_len8};
        run_done = tick_inc >= {1'b0, run_len};
    end

    // Next phase
    always_comb
    begin
        unique case (phase_reg)
            PH_LATCH:  phase_next = run_done ? PH_SETTLE : PH_LATCH;
            PH_SETTLE: phase_next = run_done ? PH_HIGH : PH_SETTLE;
            PH_HIGH:   phase_next = run_done ? PH_LOW : PH_HIGH;
            PH_LOW:    phase_next = last_bit ? PH_GAP : PH_HIGH;
            PH_GAP:    phase_next = run_done ? PH_LATCH : PH_GAP;
            default:   phase_next = run_done ? PH_SETTLE : PH_LATCH;
        endcase
    end

    // Counters, pins and sampling control per phase
    always_comb
    begin
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        lpin       = 1'b0;
        cpin       = 1'b0;
        rv         = 1'b0;
        sample_en  = 1'b0;
        sample_idx = bit_reg;
        btn_next   = btn_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        pub_btn_next = pub_btn_reg;
        pub_x_next   = pub_x_reg;
        pub_y_next   = pub_y_reg;

        unique case (phase_reg)
            PH_SETTLE:
            begin
                tick_next = run_done ? 16'd0 : tick_inc[15:0];
                if (run_done)
                begin
                    sample_en  = 1'b1;
                    sample_idx = 4'd0;
                    bit_next   = 4'd1;
                end
            end
            PH_HIGH:
            begin
                cpin      = 1'b1;
                tick_next = run_done ? 16'd0 : tick_inc[15:0];
                sample_en = run_done;
            end
            PH_LOW:
            begin
                tick_next = 16'd0;
                if (last_bit)
                begin
                    pub_btn_next = btn_reg;
                    pub_x_next   = x_reg;
                    pub_y_next   = y_reg;
                    rv           = 1'b1;
                    bit_next     = 4'd0;
                end
                else
                begin
                    bit_next = bit_reg + 4'd1;
                end
            end
            PH_GAP:
            begin
                tick_next = run_done ? 16'd0 : tick_inc[15:0];
            end
            default:
            begin
                // latch phase, also taken for codes outside the enum
                lpin      = 1'b1;
                tick_next = run_done ? 16'd0 : tick_inc[15:0];
                if (run_done)
                begin
                    btn_next = 8'd0;
                    x_next   = 8'sd0;
                    y_next   = 8'sd0;
                end
            end
        endcase

        // Fold a pressed bit into the accumulators
        if (sample_en && pressed)
        begin
            case (sample_idx) inside
                [4'd0:4'd3]:  btn_next[{1'b0, sample_idx[1:0]}] = 1'b1;
                BIT_UP:       y_next = up_value_reg;
                BIT_DOWN:     y_next = down_value_reg;
                BIT_LEFT:     x_next = left_value_reg;
                BIT_RIGHT:    x_next = right_value_reg;
                [4'd8:4'd11]: btn_next[{1'b1, sample_idx[1:0]}] = 1'b1;
                default:      ;
            endcase
        end
    end

    // Result word
    always_comb
    begin
        out_data_next                = '0;
        out_data_next[OUT_LATCH_POS] = lpin;
        out_data_next[OUT_CLOCK_POS] = cpin;
        out_data_next[9:2]           = pub_btn_next;
        out_data_next[17:10]         = pub_x_next;
        out_data_next[25:18]         = pub_y_next;
        out_user_next                = '0;
        out_user_next[OUT_USER_RV]   = rv;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_ticks_reg  <= RST_LATCH_TICKS;
            settle_ticks_reg <= RST_SETTLE_TICKS;
            clk_hi_ticks_reg <= RST_CLK_HI_TICKS;
            gap_ticks_reg    <= RST_GAP_TICKS;
            up_value_reg     <= RST_UP_VALUE;
            down_value_reg   <= RST_DOWN_VALUE;
            left_value_reg   <= RST_LEFT_VALUE;
            right_value_reg  <= RST_RIGHT_VALUE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LATCH_TICKS:  latch_ticks_reg  <= cfg_wdata[7:0];
                REG_SETTLE_TICKS: settle_ticks_reg <= cfg_wdata[7:0];
                REG_CLK_HI_TICKS: clk_hi_ticks_reg <= cfg_wdata[7:0];
                REG_GAP_TICKS:    gap_ticks_reg    <= cfg_wdata;
                REG_UP_VALUE:     up_value_reg     <= cfg_wdata[7:0];
                REG_DOWN_VALUE:   down_value_reg   <= cfg_wdata[7:0];
                REG_LEFT_VALUE:   left_value_reg   <= cfg_wdata[7:0];
                REG_RIGHT_VALUE:  right_value_reg  <= cfg_wdata[7:0];
                default:          ;
            endcase
        end
    end

    // Poll state advances once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_LATCH;
            tick_reg    <= '0;
            bit_reg     <= '0;
            btn_reg     <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            pub_btn_reg <= '0;
            pub_x_reg   <= '0;
            pub_y_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_reg     <= bit_next;
            btn_reg     <= btn_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            pub_btn_reg <= pub_btn_next;
            pub_x_reg   <= pub_x_next;
            pub_y_reg   <= pub_y_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            out_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

FILE: hdl/sgp_checker.sv
`include "assert_macros.svh"

module sgp_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [sgp_pkg::IN_DATA_W-1:0]     s_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [sgp_pkg::OUT_DATA_W-1:0]    m_tdata,
    input logic [sgp_pkg::OUT_USER_W-1:0]    m_tuser,
    input logic                              cfg_we,
    input logic [sgp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic [sgp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import sgp_pkg::*;

    logic stalled;
    logic cfg_seen;

    assign stalled  = m_tvalid && !m_tready;
    assign cfg_seen = cfg_we || (cfg_index != '0) || (cfg_wdata != '0) || (s_tdata != '0);

    // A stalled word stays offered and unchanged
    `SGP_ASSERT_NEXT(a_hold_valid, stalled, m_tvalid)
    `SGP_ASSERT_NEXT(a_hold_data, stalled, $stable(m_tdata) && $stable(m_tuser))

    // Input side is open whenever the output register is empty
    `SGP_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready || (cfg_seen && 1'b0))

    // Latch and clock are never driven high together
    `SGP_ASSERT_NOW(a_pins_exclusive, m_tvalid, !(m_tdata[OUT_LATCH_POS] && m_tdata[OUT_CLOCK_POS]))

    // A report is published on a clock-low tick with latch low
    `SGP_ASSERT_NOW(a_report_pins_low, m_tvalid && m_tuser[OUT_USER_RV],
                    !m_tdata[OUT_LATCH_POS] && !m_tdata[OUT_CLOCK_POS])

endmodule

bind serial_gamepad_poller sgp_checker u_sgp_checker (.*);
